// ----- design/pq_pkg.sv -----
// types, constants and codes shared by the priority queue files
package pq_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int TAG_BITS    = 16;

	localparam int IDX_W   = $clog2(QUEUE_DEPTH);
	localparam int OCC_W   = $clog2(QUEUE_DEPTH + 1);
	localparam int CMD_W   = 3;
	localparam int PRIO_W  = 8;
	localparam int JTAG_W  = 16;
	localparam int PLOAD_W = 32;
	localparam int STAT_W  = 2;
	localparam int COUNT_W = 5;

	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH   = 3'd0,
		CMD_POP    = 3'd1,
		CMD_PEEK   = 3'd2,
		CMD_REMOVE = 3'd3,
		CMD_CLEAR  = 3'd4
	} cmd_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK    = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_FULL  = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PUSH,
		ST_PLACE,
		ST_SEARCH,
		ST_SHIFT,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [PRIO_W-1:0]   prio;
		logic [TAG_BITS-1:0] tag;
		logic [PLOAD_W-1:0]  payload;
	} entry_t;

	typedef struct packed {
		logic       we;
		logic [IDX_W-1:0] addr;
		entry_t     data;
	} mem_wr_t;

	typedef struct packed {
		logic [CMD_W-1:0] command;
		entry_t           entry;
	} req_t;

	typedef struct packed {
		status_t            status;
		entry_t             entry;
		logic [COUNT_W-1:0] count;
	} res_t;

endpackage

// ----- design/pq_if.sv -----
// command and result channel interfaces of the priority queue
interface pq_req_if import pq_pkg::*;;
	logic                 valid;
	logic                 ready;
	logic [CMD_W-1:0]     command;
	logic [PRIO_W-1:0]    priority_req;
	logic [JTAG_W-1:0]    job_tag;
	logic [PLOAD_W-1:0]   job_payload;

	modport source (output valid, command, priority_req, job_tag, job_payload, input ready);
	modport sink (input valid, command, priority_req, job_tag, job_payload, output ready);
endinterface

interface pq_rsp_if import pq_pkg::*;;
	logic                 valid;
	logic                 ready;
	logic [STAT_W-1:0]    status;
	logic [PRIO_W-1:0]    out_priority;
	logic [JTAG_W-1:0]    out_tag;
	logic [PLOAD_W-1:0]   out_payload;
	logic [COUNT_W-1:0]   entry_count;

	modport source (output valid, status, out_priority, out_tag, out_payload, entry_count,
		input ready);
	modport sink (input valid, status, out_priority, out_tag, out_payload, entry_count,
		output ready);
endinterface

// ----- design/pq_mem.sv -----
// entry store with one write port and one registered read port
module pq_mem import pq_pkg::*; (
	input  logic             clk,
	input  mem_wr_t          wr,
	input  logic [IDX_W-1:0] raddr,
	output entry_t           rdata
);

	entry_t mem_q [QUEUE_DEPTH];
	entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (wr.we) begin
			mem_q[wr.addr] <= wr.data;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- design/pq_seq.sv -----
// sequencer: scans, shifts and compares one entry per cycle
module pq_seq import pq_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  req_t             req,
	input  logic             res_free,
	output logic             res_valid,
	output res_t             res,
	output mem_wr_t          mem_wr,
	output logic [IDX_W-1:0] mem_raddr,
	input  entry_t           mem_rdata
);

	state_t           state_q, state_d;
	logic [OCC_W-1:0] occ_q;
	logic [IDX_W-1:0] idx_q;
	cmd_t             cmd_q;
	status_t          status_q;
	entry_t           new_q;
	entry_t           res_entry_q;

	logic acc;
	logic is_full;
	logic is_empty;
	logic lt;
	logic match;
	logic last;
	logic shift_last;
	logic idx_zero;

	assign in_ready   = (state_q == ST_IDLE);
	assign acc        = in_valid && in_ready;
	assign is_full    = (occ_q == OCC_W'(QUEUE_DEPTH));
	assign is_empty   = (occ_q == '0);
	assign lt         = (mem_rdata.prio < new_q.prio);
	assign match      = (cmd_q != CMD_REMOVE) || (mem_rdata.tag == new_q.tag);
	assign last       = ((OCC_W'(idx_q) + OCC_W'(1)) == occ_q);
	assign shift_last = ((OCC_W'(idx_q) + OCC_W'(2)) == occ_q);
	assign idx_zero   = (idx_q == '0);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (acc) begin
					case (cmd_t'(req.command))
						CMD_PUSH: begin
							state_d = (is_full || is_empty) ? ST_DONE : ST_PUSH;
						end
						CMD_POP, CMD_PEEK, CMD_REMOVE: begin
							state_d = is_empty ? ST_DONE : ST_SEARCH;
						end
						default: begin
							state_d = ST_DONE;
						end
					endcase
				end
			end
			ST_PUSH: begin
				if (!lt) begin
					state_d = ST_DONE;
				end else if (idx_zero) begin
					state_d = ST_PLACE;
				end
			end
			ST_PLACE: begin
				state_d = ST_DONE;
			end
			ST_SEARCH: begin
				if (match) begin
					state_d = (cmd_q == CMD_PEEK || last) ? ST_DONE : ST_SHIFT;
				end else if (last) begin
					state_d = ST_DONE;
				end
			end
			ST_SHIFT: begin
				if (shift_last) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (res_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// memory control and result handoff
	always_comb begin
		mem_raddr      = idx_q;
		mem_wr.we      = 1'b0;
		mem_wr.addr    = idx_q;
		mem_wr.data    = mem_rdata;
		res_valid      = 1'b0;
		case (state_q)
			ST_IDLE: begin
				mem_raddr = (cmd_t'(req.command) == CMD_PUSH) ?
					IDX_W'(occ_q - OCC_W'(1)) : '0;
				if (acc && cmd_t'(req.command) == CMD_PUSH && is_empty) begin
					mem_wr.we   = 1'b1;
					mem_wr.addr = '0;
					mem_wr.data = req.entry;
				end
			end
			ST_PUSH: begin
				mem_raddr   = idx_q - IDX_W'(1);
				mem_wr.we   = 1'b1;
				mem_wr.addr = idx_q + IDX_W'(1);
				mem_wr.data = lt ? mem_rdata : new_q;
			end
			ST_PLACE: begin
				mem_wr.we   = 1'b1;
				mem_wr.addr = '0;
				mem_wr.data = new_q;
			end
			ST_SEARCH: begin
				mem_raddr = idx_q + IDX_W'(1);
			end
			ST_SHIFT: begin
				mem_raddr   = idx_q + IDX_W'(2);
				mem_wr.we   = 1'b1;
				mem_wr.addr = idx_q;
				mem_wr.data = mem_rdata;
			end
			ST_DONE: begin
				res_valid = res_free;
			end
			default: begin
				res_valid = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			occ_q    <= '0;
			idx_q    <= '0;
			cmd_q    <= CMD_CLEAR;
			status_q <= STAT_OK;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_IDLE: begin
					if (acc) begin
						cmd_q    <= cmd_t'(req.command);
						status_q <= STAT_OK;
						idx_q    <= (cmd_t'(req.command) == CMD_PUSH) ?
							IDX_W'(occ_q - OCC_W'(1)) : '0;
						case (cmd_t'(req.command))
							CMD_PUSH: begin
								if (is_full) begin
									status_q <= STAT_FULL;
								end else if (is_empty) begin
									occ_q <= OCC_W'(1);
								end
							end
							CMD_POP, CMD_PEEK, CMD_REMOVE: begin
								if (is_empty) begin
									status_q <= STAT_EMPTY;
								end
							end
							CMD_CLEAR: begin
								occ_q <= '0;
							end
							default: begin
								occ_q <= occ_q;
							end
						endcase
					end
				end
				ST_PUSH: begin
					if (!lt) begin
						occ_q <= occ_q + OCC_W'(1);
					end else if (!idx_zero) begin
						idx_q <= idx_q - IDX_W'(1);
					end
				end
				ST_PLACE: begin
					occ_q <= occ_q + OCC_W'(1);
				end
				ST_SEARCH: begin
					if (match) begin
						if (cmd_q != CMD_PEEK && last) begin
							occ_q <= occ_q - OCC_W'(1);
						end
					end else if (last) begin
						status_q <= STAT_EMPTY;
					end else begin
						idx_q <= idx_q + IDX_W'(1);
					end
				end
				ST_SHIFT: begin
					if (shift_last) begin
						occ_q <= occ_q - OCC_W'(1);
					end else begin
						idx_q <= idx_q + IDX_W'(1);
					end
				end
				default: begin
					idx_q <= idx_q;
				end
			endcase
		end
	end

	// job fields and the returned entry
	always_ff @(posedge clk) begin
		if (acc) begin
			new_q       <= req.entry;
			res_entry_q <= '0;
		end else if (state_q == ST_SEARCH && match) begin
			res_entry_q <= mem_rdata;
		end
	end

	assign res.status = status_q;
	assign res.entry  = res_entry_q;
	assign res.count  = COUNT_W'(occ_q);

endmodule

// ----- design/sorted_priority_queue.sv -----
// sorted priority queue top level: entry store, sequencer and result register
// clear, unknown commands and full or empty cases go straight to the result; peek reads the head,
// push scans entries from the tail and pop or remove from the head, then closes the gap
// one entry is compared or moved per cycle through the store's single read and write port
// one item at a time: the next is taken once the result is registered
// reset clears the count and the sequencer; entry storage is not cleared
module sorted_priority_queue import pq_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	pq_req_if.sink   req,
	pq_rsp_if.source rsp
);

	req_t             req_s;
	res_t             res_s;
	logic             res_valid;
	logic             res_free;
	mem_wr_t          mem_wr;
	logic [IDX_W-1:0] mem_raddr;
	entry_t           mem_rdata;

	logic             valid_q;
	res_t             out_q;

	assign req_s.command       = req.command;
	assign req_s.entry.prio    = req.priority_req;
	assign req_s.entry.tag     = TAG_BITS'(req.job_tag);
	assign req_s.entry.payload = req.job_payload;

	assign res_free = !valid_q || rsp.ready;

	pq_mem u_mem (
		.clk   (clk),
		.wr    (mem_wr),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	pq_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.req       (req_s),
		.res_free  (res_free),
		.res_valid (res_valid),
		.res       (res_s),
		.mem_wr    (mem_wr),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (res_valid) begin
			valid_q <= 1'b1;
		end else if (rsp.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			out_q <= res_s;
		end
	end

	assign rsp.valid        = valid_q;
	assign rsp.status       = out_q.status;
	assign rsp.out_priority = out_q.entry.prio;
	assign rsp.out_tag      = JTAG_W'(out_q.entry.tag);
	assign rsp.out_payload  = out_q.entry.payload;
	assign rsp.entry_count  = out_q.count;

endmodule
